FILE: hw/rtl/range_scan_median_filter_macros.svh
// Assertion macros shared by the range scan median filter RTL.
`ifndef RANGE_SCAN_MEDIAN_FILTER_MACROS_SVH
`define RANGE_SCAN_MEDIAN_FILTER_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define RSMF_ASSERT_SAME(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// The consequence must hold in the cycle after the condition.
`define RSMF_ASSERT_NEXT(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

FILE: hw/rtl/rsmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsmf_pkg;

   localparam int unsigned DIST_W     = 16;
   localparam int unsigned WIN_LEN    = 5;
   localparam int unsigned HIST_LEN   = WIN_LEN - 1;
   localparam int unsigned MID        = WIN_LEN / 2;
   localparam int unsigned HIST_IDX_W = $clog2(HIST_LEN);
   localparam int unsigned IDX_W      = $clog2(WIN_LEN);
   localparam int unsigned CNT_W      = 3;
   localparam int unsigned NRES_W     = 3;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   typedef logic [DIST_W-1:0] dist_type;
   typedef dist_type [WIN_LEN-1:0] window_type;

   typedef struct packed {
      logic               owe;
      logic               filt;
      logic [NRES_W-1:0]  nres;
      logic               last_final;
      logic               set_owe;
      window_type         samples;
   } cmd_type;

   localparam dist_type MAX_RANGE_RESET = 16'd4000;

   localparam logic [CNT_W-1:0] CNT_HIST = 3'd4;
   localparam logic [CNT_W-1:0] CNT_FULL = 3'd5;

   localparam logic [NRES_W-1:0] NRES_NONE        = 3'd0;
   localparam logic [NRES_W-1:0] NRES_FIRST       = 3'd3;
   localparam logic [NRES_W-1:0] NRES_FIRST_LAST  = 3'd4;
   localparam logic [NRES_W-1:0] NRES_STEADY      = 3'd1;
   localparam logic [NRES_W-1:0] NRES_STEADY_LAST = 3'd3;

   localparam logic [CSR_ADDR_W-3:0] REG_MAX_RANGE = 1'b0;

endpackage

`default_nettype wire

FILE: hw/rtl/rsmf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rsmf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rsmf_pkg::dist_type dist_in,
   input  logic               last_in,
   input  logic               q_full,
   output logic               q_push,
   output rsmf_pkg::cmd_type  cmd
);
   import rsmf_pkg::*;

   dist_type           store_ff [HIST_LEN];
   dist_type           store_in [HIST_LEN];
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic               owe_ff;
   logic               owe_in;
   logic               accept;
   logic               filt;

   assign accept = push && !q_full;
   assign filt   = (cnt_ff >= CNT_HIST);
   assign q_push = accept && (owe_ff || last_in || filt);

   always_comb begin
      cmd.owe     = owe_ff;
      cmd.filt    = filt;
      cmd.set_owe = (cnt_ff == CNT_HIST) && last_in;
      for (int i = 0; i < HIST_LEN; i++) begin
         if (filt || (CNT_W'(i) < cnt_ff)) begin
            cmd.samples[i] = store_ff[i];
         end else begin
            cmd.samples[i] = dist_in;
         end
      end
      cmd.samples[HIST_LEN] = dist_in;
      if (!filt) begin
         cmd.nres       = last_in ? (NRES_W'(cnt_ff) + NRES_W'(1)) : NRES_NONE;
         cmd.last_final = 1'b1;
      end else if (cnt_ff == CNT_HIST) begin
         cmd.nres       = last_in ? NRES_FIRST_LAST : NRES_FIRST;
         cmd.last_final = 1'b0;
      end else begin
         cmd.nres       = last_in ? NRES_STEADY_LAST : NRES_STEADY;
         cmd.last_final = last_in;
      end
   end

   always_comb begin
      store_in = store_ff;
      cnt_in   = cnt_ff;
      owe_in   = owe_ff;
      if (accept) begin
         owe_in = cmd.set_owe;
         if (filt) begin
            for (int i = 0; i < HIST_LEN - 1; i++) begin
               store_in[i] = store_ff[i + 1];
            end
            store_in[HIST_LEN-1] = dist_in;
            cnt_in = last_in ? '0 : CNT_FULL;
         end else begin
            store_in[cnt_ff[HIST_IDX_W-1:0]] = dist_in;
            cnt_in = last_in ? '0 : (cnt_ff + CNT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         owe_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         owe_ff <= owe_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rsmf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module rsmf_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rsmf_pkg::cmd_type wr_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output rsmf_pkg::cmd_type rd_cmd
);
   import rsmf_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

   cmd_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_in;
   logic [CNT_QW-1:0]   count_ff;
   logic [CNT_QW-1:0]   count_in;
   logic                push_fire;
   logic                pop_fire;

   assign full      = (count_ff == CNT_QW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign push_fire = push && !full;
   assign pop_fire  = pop && !empty;
   assign rd_cmd    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_ff + PTR_W'(1));
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_ff + PTR_W'(1));
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rsmf_sort.sv
`timescale 1ns / 1ps
`default_nettype none

module rsmf_sort (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rsmf_pkg::cmd_type in_cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output rsmf_pkg::cmd_type out_cmd
);
   import rsmf_pkg::*;

   function automatic window_type cmp_swap(input window_type w, input int unsigned lo,
                                           input int unsigned hi);
      window_type r;
      r = w;
      if (w[lo] > w[hi]) begin
         r[lo] = w[hi];
         r[hi] = w[lo];
      end
      return r;
   endfunction

   logic      a_valid_ff;
   logic      a_valid_in;
   cmd_type   a_cmd_ff;
   cmd_type   a_cmd_in;
   logic      b_valid_ff;
   logic      b_valid_in;
   cmd_type   b_cmd_ff;
   cmd_type   b_cmd_in;
   logic      a_ready;
   logic      b_ready;

   assign b_ready   = !b_valid_ff || out_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign in_ready  = a_ready;
   assign out_valid = b_valid_ff;
   assign out_cmd   = b_cmd_ff;

   // Pass-through commands keep their samples in scan order.
   always_comb begin
      a_cmd_in = in_cmd;
      if (in_cmd.filt) begin
         a_cmd_in.samples = cmp_swap(a_cmd_in.samples, 0, 1);
         a_cmd_in.samples = cmp_swap(a_cmd_in.samples, 3, 4);
         a_cmd_in.samples = cmp_swap(a_cmd_in.samples, 2, 4);
         a_cmd_in.samples = cmp_swap(a_cmd_in.samples, 2, 3);
         a_cmd_in.samples = cmp_swap(a_cmd_in.samples, 1, 4);
      end
      b_cmd_in = a_cmd_ff;
      if (a_cmd_ff.filt) begin
         b_cmd_in.samples = cmp_swap(b_cmd_in.samples, 0, 3);
         b_cmd_in.samples = cmp_swap(b_cmd_in.samples, 0, 2);
         b_cmd_in.samples = cmp_swap(b_cmd_in.samples, 1, 3);
         b_cmd_in.samples = cmp_swap(b_cmd_in.samples, 1, 2);
      end
      a_valid_in = a_ready ? in_valid : a_valid_ff;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_cmd_ff <= a_cmd_in;
      end
      if (b_ready) begin
         b_cmd_ff <= b_cmd_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rsmf_expand.sv
`timescale 1ns / 1ps
`default_nettype none

module rsmf_expand (
   input  logic               clock,
   input  logic               reset,
   input  rsmf_pkg::dist_type max_range,
   input  logic               in_valid,
   output logic               in_ready,
   input  rsmf_pkg::cmd_type  in_cmd,
   output logic               out_valid,
   input  logic               out_pop,
   output rsmf_pkg::dist_type dist_out,
   output logic               last_out,
   output logic               short_scan
);
   import rsmf_pkg::*;

   function automatic logic no_return(input dist_type v, input dist_type limit);
      return ({1'b0, v} + (DIST_W + 1)'(1)) >= {1'b0, limit};
   endfunction

   logic                busy_ff;
   logic                busy_in;
   logic                owe_left_ff;
   logic                owe_left_in;
   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W-1:0]    idx_in;
   logic [NRES_W-1:0]   nres_ff;
   logic [NRES_W-1:0]   nres_in;
   logic                short_ff;
   logic                short_in;
   logic                last_final_ff;
   logic                last_final_in;
   window_type          samples_ff;
   window_type          samples_in;
   dist_type            f_ff;
   dist_type            f_in;
   dist_type            owe_val_ff;
   dist_type            owe_val_in;
   logic                out_valid_ff;
   logic                out_valid_in;
   dist_type            out_dist_ff;
   dist_type            out_dist_in;
   logic                out_last_ff;
   logic                out_last_in;
   logic                out_short_ff;
   logic                out_short_in;
   dist_type            f_new;
   logic                out_free;
   logic                emit;
   logic                at_end;
   logic                finish;
   logic                load;

   // A no-return median falls back to the next smaller value, then to the smallest.
   always_comb begin
      if (no_return(in_cmd.samples[MID], max_range)) begin
         if (no_return(in_cmd.samples[MID-1], max_range)) begin
            f_new = in_cmd.samples[MID-2];
         end else begin
            f_new = in_cmd.samples[MID-1];
         end
      end else begin
         f_new = in_cmd.samples[MID];
      end
   end

   assign out_free   = !out_valid_ff || out_pop;
   assign emit       = busy_ff && out_free;
   assign at_end     = (NRES_W'(idx_ff) == (nres_ff - NRES_W'(1)));
   assign finish     = emit && (owe_left_ff ? (nres_ff == NRES_NONE) : at_end);
   assign in_ready   = !busy_ff || finish;
   assign load       = in_valid && in_ready;
   assign out_valid  = out_valid_ff;
   assign dist_out   = out_dist_ff;
   assign last_out   = out_last_ff;
   assign short_scan = out_short_ff;

   always_comb begin
      busy_in       = busy_ff;
      owe_left_in   = owe_left_ff;
      idx_in        = idx_ff;
      nres_in       = nres_ff;
      short_in      = short_ff;
      last_final_in = last_final_ff;
      samples_in    = samples_ff;
      f_in          = f_ff;
      owe_val_in    = owe_val_ff;
      out_valid_in  = out_valid_ff;
      out_dist_in   = out_dist_ff;
      out_last_in   = out_last_ff;
      out_short_in  = out_short_ff;

      if (emit) begin
         out_valid_in = 1'b1;
         if (owe_left_ff) begin
            out_dist_in  = owe_val_ff;
            out_last_in  = 1'b1;
            out_short_in = 1'b0;
            owe_left_in  = 1'b0;
         end else begin
            out_dist_in  = short_ff ? samples_ff[idx_ff] : f_ff;
            out_last_in  = last_final_ff && at_end;
            out_short_in = short_ff;
            idx_in       = idx_ff + IDX_W'(1);
         end
      end else if (out_pop) begin
         out_valid_in = 1'b0;
      end

      if (finish) begin
         busy_in = 1'b0;
      end

      if (load) begin
         busy_in       = 1'b1;
         owe_left_in   = in_cmd.owe;
         idx_in        = '0;
         nres_in       = in_cmd.nres;
         short_in      = !in_cmd.filt;
         last_final_in = in_cmd.last_final;
         samples_in    = in_cmd.samples;
         f_in          = f_new;
         if (in_cmd.set_owe) begin
            owe_val_in = f_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         owe_left_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         owe_left_ff  <= owe_left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      nres_ff       <= nres_in;
      short_ff      <= short_in;
      last_final_ff <= last_final_in;
      samples_ff    <= samples_in;
      f_ff          <= f_in;
      owe_val_ff    <= owe_val_in;
      out_dist_ff   <= out_dist_in;
      out_last_ff   <= out_last_in;
      out_short_ff  <= out_short_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/range_scan_median_filter.sv
// Channel  Direction  Handshake                    Contents
// req      in         req_push, req_full           req_dist_in, req_last_in
// rsp      out        rsp_empty, rsp_pop           rsp_dist_out, rsp_last_out, rsp_short_scan
// csr      in/out     APB, csr_pready tied high    max_range at byte address 0
//
// One sample transaction can be taken every cycle while req_full is low; it yields zero to
// four results. The expander hands out one result per cycle while rsp_pop takes them, which
// sets the sustained rate: one sample per cycle while each sample gives one result, and fewer
// at the ends of a scan. A result passes through the command queue, two compare-exchange
// stages, then the expander and its output register.
// Reset clears the scan position and every valid bit; max_range returns to 4000. The command
// queue lets the input run on while the output is stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "range_scan_median_filter_macros.svh"

module range_scan_median_filter #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  rsmf_pkg::dist_type                    req_dist_in,
   input  logic                                  req_last_in,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output rsmf_pkg::dist_type                    rsp_dist_out,
   output logic                                  rsp_last_out,
   output logic                                  rsp_short_scan,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rsmf_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [rsmf_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [rsmf_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import rsmf_pkg::*;

   dist_type   max_range_ff;
   dist_type   max_range_in;
   logic       reg_hit;
   logic       q_push;
   logic       q_full;
   logic       q_empty;
   logic       q_pop;
   cmd_type    front_cmd;
   cmd_type    q_cmd;
   logic       sort_ready;
   logic       sort_valid;
   cmd_type    sort_cmd;
   logic       exp_ready;
   logic       out_valid;

   assign reg_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_MAX_RANGE);
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_hit ? CSR_DATA_W'(max_range_ff) : '0;

   always_comb begin
      max_range_in = max_range_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         max_range_in = csr_pwdata[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff <= MAX_RANGE_RESET;
      end else begin
         max_range_ff <= max_range_in;
      end
   end

   assign req_full  = q_full;
   assign q_pop     = sort_ready;
   assign rsp_empty = !out_valid;

   rsmf_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .dist_in (req_dist_in),
      .last_in (req_last_in),
      .q_full  (q_full),
      .q_push  (q_push),
      .cmd     (front_cmd)
   );

   rsmf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_cmd (front_cmd),
      .full   (q_full),
      .pop    (q_pop),
      .empty  (q_empty),
      .rd_cmd (q_cmd)
   );

   rsmf_sort u_sort (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_empty),
      .in_ready  (sort_ready),
      .in_cmd    (q_cmd),
      .out_valid (sort_valid),
      .out_ready (exp_ready),
      .out_cmd   (sort_cmd)
   );

   rsmf_expand u_expand (
      .clock      (clock),
      .reset      (reset),
      .max_range  (max_range_ff),
      .in_valid   (sort_valid),
      .in_ready   (exp_ready),
      .in_cmd     (sort_cmd),
      .out_valid  (out_valid),
      .out_pop    (rsp_pop),
      .dist_out   (rsp_dist_out),
      .last_out   (rsp_last_out),
      .short_scan (rsp_short_scan)
   );

   `RSMF_ASSERT_NEXT(a_short_run, !rsp_empty && rsp_pop && rsp_short_scan && !rsp_last_out, !rsp_empty && rsp_short_scan, "short scan transaction interrupted")
   `RSMF_ASSERT_SAME(a_reset_empty, $past(reset), rsp_empty, "result present right after reset")

endmodule

`default_nettype wire

FILE: dv/tb_range_scan_median_filter.sv
`timescale 1ns / 1ps

module tb_range_scan_median_filter;
   import rsmf_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_SAMPLES = 45;
   localparam logic [CSR_ADDR_W-1:0] MAX_RANGE_ADDR = {REG_MAX_RANGE, 2'b00};

   typedef struct packed {
      dist_type dist_value;
      logic     last_flag;
      logic     short_flag;
   } filtered_sample_t;

   typedef struct packed {
      dist_type range_mm;
      logic     last;
      logic     typed;
      dist_type want_dist;
      logic     want_short;
   } scan_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   dist_type req_dist_in = '0;
   logic req_last_in = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   dist_type rsp_dist_out;
   logic rsp_last_out;
   logic rsp_short_scan;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   range_scan_median_filter dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_dist_in(req_dist_in),
      .req_last_in(req_last_in),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_dist_out(rsp_dist_out),
      .rsp_last_out(rsp_last_out),
      .rsp_short_scan(rsp_short_scan),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow of the filter state.
   dist_type recent [HIST_LEN];
   int unsigned scan_pos = 0;
   dist_type held_median = '0;
   logic median_owed = 1'b0;
   dist_type range_limit = MAX_RANGE_RESET;

   filtered_sample_t filtered_q [$];
   int error_count = 0;
   int samples_sent = 0;
   int results_checked = 0;
   int push_idle_pct = 0;
   int pop_stall_pct = 0;
   int idle_cycles = 0;

   initial begin
      for (int i = 0; i < HIST_LEN; i++) begin
         recent[i] = '0;
      end
   end

   function automatic dist_type choose_median(input window_type win);
      window_type sorted;
      dist_type swap;
      int threshold;
      sorted = win;
      for (int i = 0; i < WIN_LEN - 1; i++) begin
         for (int j = 0; j < WIN_LEN - 1 - i; j++) begin
            if (sorted[j] > sorted[j + 1]) begin
               swap = sorted[j];
               sorted[j] = sorted[j + 1];
               sorted[j + 1] = swap;
            end
         end
      end
      threshold = int'(range_limit) - 1;
      if (int'(sorted[MID]) >= threshold) begin
         if (int'(sorted[MID - 1]) >= threshold) begin
            return sorted[MID - 2];
         end
         return sorted[MID - 1];
      end
      return sorted[MID];
   endfunction

   function automatic int filter_sample(input dist_type range_mm, input logic last,
                                        output filtered_sample_t res [4]);
      int n;
      int total;
      int c;
      window_type win;
      dist_type median;
      n = 0;
      for (int i = 0; i < 4; i++) begin
         res[i] = '0;
      end
      if (median_owed) begin
         res[n] = '{held_median, 1'b1, 1'b0};
         n++;
         median_owed = 1'b0;
      end
      c = scan_pos;
      if (c < HIST_LEN) begin
         recent[c] = range_mm;
         if (last) begin
            for (int i = 0; i <= c; i++) begin
               res[n] = '{recent[i], i == c, 1'b1};
               n++;
            end
            scan_pos = 0;
         end else begin
            scan_pos = c + 1;
         end
         return n;
      end
      for (int i = 0; i < HIST_LEN; i++) begin
         win[i] = recent[i];
      end
      win[HIST_LEN] = range_mm;
      median = choose_median(win);
      for (int i = 0; i < HIST_LEN - 1; i++) begin
         recent[i] = recent[i + 1];
      end
      recent[HIST_LEN - 1] = range_mm;
      held_median = median;
      total = ((c == HIST_LEN) ? MID + 1 : 1) + (last ? MID : 0);
      for (int k = 0; k < total; k++) begin
         if (n < 4) begin
            res[n] = '{median, last && (k == total - 1), 1'b0};
            n++;
         end else begin
            median_owed = 1'b1;
         end
      end
      scan_pos = last ? 0 : WIN_LEN;
      return n;
   endfunction

   task automatic send_sample(input dist_type range_mm, input logic last,
                              output filtered_sample_t res [4], output int n);
      while ($urandom_range(99) < push_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_dist_in <= range_mm;
      req_last_in <= last;
      do @(posedge clock); while (req_full);
      n = filter_sample(range_mm, last, res);
      for (int i = 0; i < n; i++) begin
         filtered_q.push_back(res[i]);
      end
      samples_sent++;
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (filtered_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_range(input logic do_write, input dist_type value);
      if (do_write) begin
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b1;
         csr_paddr <= MAX_RANGE_ADDR;
         csr_pwdata <= {{(CSR_DATA_W - DIST_W){1'b0}}, value};
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         range_limit = value;
      end
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= MAX_RANGE_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {{(CSR_DATA_W - DIST_W){1'b0}}, range_limit}) begin
         $display("%0t max_range readback: expected %0d, actual %0d",
                  $time, range_limit, csr_prdata);
         error_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic dist_type draw_distance();
      int pick;
      int near;
      pick = $urandom_range(9);
      if (pick == 0) begin
         return '0;
      end else if (pick == 1) begin
         return '1;
      end else if (pick <= 4) begin
         near = int'(range_limit) - 3 + int'($urandom_range(4));
         if (near < 0) near = 0;
         if (near > 65535) near = 65535;
         return dist_type'(near);
      end
      return dist_type'($urandom_range(65535));
   endfunction

   function automatic int draw_scan_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 12) return $urandom_range(4, 1);
      if (pick < 22) return WIN_LEN;
      if (pick < 92) return $urandom_range(14, 6);
      return $urandom_range(40, 15);
   endfunction

   always @(posedge clock) begin
      filtered_sample_t want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_checked++;
            if (filtered_q.size() == 0) begin
               $display("%0t unexpected result: dist %0d last %0b short %0b",
                        $time, rsp_dist_out, rsp_last_out, rsp_short_scan);
               error_count++;
            end else begin
               want = filtered_q.pop_front();
               if (rsp_dist_out !== want.dist_value) begin
                  $display("%0t dist_out: expected %0d, actual %0d",
                           $time, want.dist_value, rsp_dist_out);
                  error_count++;
               end
               if (rsp_last_out !== want.last_flag) begin
                  $display("%0t last_out: expected %0b, actual %0b",
                           $time, want.last_flag, rsp_last_out);
                  error_count++;
               end
               if (rsp_short_scan !== want.short_flag) begin
                  $display("%0t short_scan: expected %0b, actual %0b",
                           $time, want.short_flag, rsp_short_scan);
                  error_count++;
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("tb_range_scan_median_filter failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      scan_row_t scan_rows [22];
      dist_type range_settings [PHASE_COUNT];
      filtered_sample_t res [4];
      int n;
      int phase_samples;
      int scan_len;
      scan_rows = '{
         '{16'd65535, 1'b1, 1'b1, 16'd65535, 1'b1},
         '{16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
         '{16'd65535, 1'b0, 1'b0, 16'd0,     1'b0},
         '{16'h5555,  1'b0, 1'b0, 16'd0,     1'b0},
         '{16'hAAAA,  1'b1, 1'b0, 16'd0,     1'b0},
         '{16'd10,    1'b0, 1'b0, 16'd0,     1'b0},
         '{16'd20,    1'b0, 1'b0, 16'd0,     1'b0},
         '{16'd30,    1'b0, 1'b0, 16'd0,     1'b0},
         '{16'd40,    1'b0, 1'b0, 16'd0,     1'b0},
         '{16'd50,    1'b1, 1'b1, 16'd30,    1'b0},
         '{16'd4000,  1'b0, 1'b1, 16'd30,    1'b0},
         '{16'd5000,  1'b0, 1'b0, 16'd0,     1'b0},
         '{16'd65535, 1'b0, 1'b0, 16'd0,     1'b0},
         '{16'd3999,  1'b0, 1'b0, 16'd0,     1'b0},
         '{16'd4500,  1'b1, 1'b1, 16'd3999,  1'b0},
         '{16'd100,   1'b0, 1'b1, 16'd3999,  1'b0},
         '{16'd3998,  1'b0, 1'b0, 16'd0,     1'b0},
         '{16'd4000,  1'b0, 1'b0, 16'd0,     1'b0},
         '{16'd4001,  1'b0, 1'b0, 16'd0,     1'b0},
         '{16'd200,   1'b0, 1'b1, 16'd3998,  1'b0},
         '{16'd3000,  1'b0, 1'b1, 16'd3998,  1'b0},
         '{16'd5000,  1'b1, 1'b1, 16'd3000,  1'b0}
      };
      range_settings = '{16'd65535, 16'd1, 16'd0, 16'd0, 16'd2, 16'd0, 16'd4000, 16'd65534};
      range_settings[3] = dist_type'($urandom_range(65535));
      range_settings[5] = dist_type'($urandom_range(65535));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      program_range(1'b0, '0);

      foreach (scan_rows[r]) begin
         send_sample(scan_rows[r].range_mm, scan_rows[r].last, res, n);
         if (scan_rows[r].typed) begin
            for (int i = 0; i < n; i++) begin
               if (res[i].dist_value !== scan_rows[r].want_dist ||
                   res[i].short_flag !== scan_rows[r].want_short) begin
                  $display("%0t row %0d: expected dist %0d short %0b, predicted %0d %0b",
                           $time, r, scan_rows[r].want_dist, scan_rows[r].want_short,
                           res[i].dist_value, res[i].short_flag);
                  error_count++;
               end
            end
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_results();
         program_range(1'b1, range_settings[phase]);
         case (phase % 4)
            0: begin
               push_idle_pct = 0;
               pop_stall_pct = 0;
            end
            1: begin
               push_idle_pct = 60;
               pop_stall_pct = 0;
            end
            2: begin
               push_idle_pct = 0;
               pop_stall_pct = 60;
            end
            default: begin
               push_idle_pct = 36;
               pop_stall_pct = 36;
            end
         endcase
         phase_samples = 0;
         while (phase_samples < PHASE_SAMPLES) begin
            scan_len = draw_scan_length();
            for (int j = 0; j < scan_len; j++) begin
               send_sample(draw_distance(), j == scan_len - 1, res, n);
               phase_samples++;
            end
         end
      end

      drain_results();
      repeat (16) @(posedge clock);
      $display("Sent %0d sample transactions in whole scans under %0d max_range settings.",
               samples_sent, PHASE_COUNT + 1);
      $display("Checked %0d filtered transactions, with idle and stall on both sides.",
               results_checked);
      if (filtered_q.size() != 0) begin
         $display("%0t %0d expected results never arrived", $time, filtered_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb_range_scan_median_filter passed");
      end else begin
         $display("tb_range_scan_median_filter failed");
      end
      $finish;
   end

endmodule
